// File: rtl/spe_pkg.sv
package spe_pkg;

   // Multiplier limb size; one limb product is a 32 x 32 unsigned multiply.
   localparam int LIMB = 32;

   // Fixed formats of the block.
   localparam int INT_BITS = 12;
   localparam int OUT_BITS = 48;
   localparam int OUT_FRAC = 24;
   localparam int QUOT_BITS = OUT_BITS + 1;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_HALF = 32;
   localparam int NUM_COEFS = 9;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_PAIR_0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_PAIR_1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_PAIR_2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_PAIR_3 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_LAST = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SAT      = 2'd1,
      STATUS_ZERO_DEN = 2'd2
   } status_type;

   function automatic int limb_count(input int pw);
      return (pw + LIMB - 1) / LIMB;
   endfunction

   // Partial products of a product truncated to its own width.
   function automatic int pp_count(input int pw);
      int l;
      l = limb_count(pw);
      return (l * (l + 1)) / 2;
   endfunction

   function automatic int pp_index(input int i, input int j, input int l);
      return i * l - (i * (i - 1)) / 2 + j;
   endfunction

   function automatic int tree_levels(input int terms);
      return (terms > 1) ? $clog2(terms) : 1;
   endfunction

   function automatic int level_count(input int terms, input int level);
      return (terms + (1 << level) - 1) >> level;
   endfunction

   function automatic int mul_latency(input int pw);
      return 1 + tree_levels(pp_count(pw));
   endfunction

endpackage

// File: rtl/spe_req_if.sv
interface spe_req_if #(
   parameter int COORD_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_x;
   logic signed [COORD_WIDTH-1:0] first_y;
   logic signed [COORD_WIDTH-1:0] second_x;
   logic signed [COORD_WIDTH-1:0] second_y;

   modport source (output valid, output first_x, output first_y, output second_x,
                   output second_y, input ready);
   modport sink (input valid, input first_x, input first_y, input second_x,
                 input second_y, output ready);
endinterface

// File: rtl/spe_rsp_if.sv
interface spe_rsp_if ();
   import spe_pkg::*;

   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] error_value;
   status_type          status;

   modport source (output valid, output error_value, output status, input ready);
   modport sink (input valid, input error_value, input status, output ready);
endinterface

// File: rtl/spe_csr_if.sv
interface spe_csr_if ();
   import spe_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/spe_delay.sv
module spe_delay #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

// File: rtl/spe_wmul.sv
module spe_wmul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 32,
   parameter int LATENCY = 3
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [A_WIDTH-1:0]         a,
   input  logic signed [B_WIDTH-1:0]         b,
   output logic signed [A_WIDTH+B_WIDTH-1:0] p
);
   import spe_pkg::*;

   // Signed product as the low bits of an unsigned product of the
   // sign-extended operands; only limb products below the width are formed.
   localparam int PW = A_WIDTH + B_WIDTH;
   localparam int L = limb_count(PW);
   localparam int XW = L * LIMB;
   localparam int TERMS = pp_count(PW);
   localparam int LEVELS = tree_levels(TERMS);
   localparam int NATURAL = 1 + LEVELS;

   logic [XW-1:0]     ax;
   logic [XW-1:0]     bx;
   logic [2*LIMB-1:0] pp_ff [TERMS];
   logic [PW-1:0]     placed [TERMS];
   logic [PW-1:0]     tree_ff [LEVELS][TERMS];
   logic [PW-1:0]     sum_out;

   assign ax = {{(XW-A_WIDTH){a[A_WIDTH-1]}}, a};
   assign bx = {{(XW-B_WIDTH){b[B_WIDTH-1]}}, b};

   for (genvar i = 0; i < L; i++) begin : g_row
      for (genvar j = 0; j < L - i; j++) begin : g_col
         localparam int IDX = pp_index(i, j, L);
         logic [2*LIMB-1:0]    pp_in;
         logic [XW+2*LIMB-1:0] shifted;

         assign pp_in = ax[i*LIMB +: LIMB] * bx[j*LIMB +: LIMB];

         always_ff @(posedge clock) begin
            if (en) begin
               pp_ff[IDX] <= pp_in;
            end
         end

         assign shifted = {{XW{1'b0}}, pp_ff[IDX]} << ((i + j) * LIMB);
         assign placed[IDX] = shifted[PW-1:0];
      end
   end

   // Registered pairwise adder tree.
   for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
      for (genvar j = 0; j < level_count(TERMS, k + 1); j++) begin : g_node
         logic [PW-1:0] lhs;
         logic [PW-1:0] rhs;

         if (k == 0) begin : g_first
            assign lhs = placed[2*j];
            if (2 * j + 1 < TERMS) begin : g_pair
               assign rhs = placed[2*j+1];
            end else begin : g_single
               assign rhs = '0;
            end
         end else begin : g_inner
            assign lhs = tree_ff[k-1][2*j];
            if (2 * j + 1 < level_count(TERMS, k)) begin : g_pair
               assign rhs = tree_ff[k-1][2*j+1];
            end else begin : g_single
               assign rhs = '0;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               tree_ff[k][j] <= lhs + rhs;
            end
         end
      end
   end

   assign sum_out = tree_ff[LEVELS-1][0];

   if (LATENCY > NATURAL) begin : g_pad
      logic [PW-1:0] padded;

      spe_delay #(
         .WIDTH (PW),
         .DEPTH (LATENCY - NATURAL)
      ) u_pad (
         .clock (clock),
         .en    (en),
         .din   (sum_out),
         .dout  (padded)
      );

      assign p = padded;
   end else begin : g_nopad
      assign p = sum_out;
   end

endmodule

// File: rtl/spe_divider.sv
module spe_divider #(
   parameter int NUM_WIDTH = 195,
   parameter int DEN_WIDTH = 147
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [NUM_WIDTH-1:0]          num,
   input  logic [DEN_WIDTH-1:0]          den,
   output logic [spe_pkg::QUOT_BITS-1:0] quot,
   output logic                          den_zero
);
   import spe_pkg::*;

   // One quotient bit per stage, most significant first. The top bit is set
   // when the quotient does not fit below it.
   localparam int CW = (NUM_WIDTH > DEN_WIDTH + QUOT_BITS - 1) ?
                       NUM_WIDTH : DEN_WIDTH + QUOT_BITS - 1;

   logic [CW-1:0]        rem_ff  [QUOT_BITS-1];
   logic [DEN_WIDTH-1:0] den_ff  [QUOT_BITS-1];
   logic [QUOT_BITS-1:0] quot_ff [QUOT_BITS];
   logic                 zero_ff [QUOT_BITS];

   for (genvar s = 0; s < QUOT_BITS; s++) begin : g_stage
      localparam int SHIFT = QUOT_BITS - 1 - s;
      logic [CW-1:0]        rem_prev;
      logic [DEN_WIDTH-1:0] den_prev;
      logic [QUOT_BITS-1:0] quot_prev;
      logic                 zero_prev;
      logic [CW-1:0]        trial;
      logic                 fits;
      logic [QUOT_BITS-1:0] quot_in;

      if (s == 0) begin : g_head
         assign rem_prev  = CW'(num);
         assign den_prev  = den;
         assign quot_prev = '0;
         assign zero_prev = (den == '0);
      end else begin : g_body
         assign rem_prev  = rem_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign quot_prev = quot_ff[s-1];
         assign zero_prev = zero_ff[s-1];
      end

      assign trial   = CW'(den_prev) << SHIFT;
      assign fits    = (rem_prev >= trial);
      assign quot_in = quot_prev | ({{(QUOT_BITS-1){1'b0}}, fits} << SHIFT);

      always_ff @(posedge clock) begin
         if (en) begin
            quot_ff[s] <= quot_in;
            zero_ff[s] <= zero_prev;
         end
      end

      if (s < QUOT_BITS - 1) begin : g_carry
         logic [CW-1:0] rem_in;

         assign rem_in = fits ? (rem_prev - trial) : rem_prev;

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_prev;
            end
         end
      end
   end

   assign quot     = quot_ff[QUOT_BITS-1];
   assign den_zero = zero_ff[QUOT_BITS-1];

endmodule

// File: rtl/sampson_epipolar_error_unit.sv
// Squared Sampson epipolar error engine, one point correspondence per request.
// Software first writes the nine matrix entries through the csr channel
// (indexes 0 to 3 carry two entries each, index 4 the last one); writes are
// always taken and belong only to times when no request is in flight, a
// rule for software that the block itself does not enforce. Each request on
// the req channel carries a point of the first image and its match in the
// second; each response on the rsp channel carries the error in unsigned
// Q24.24 and a status: ok, saturated, or zero denominator. Throughput is
// one request per clock while the response buffer has a free entry. The 49
// stages of the restoring divider make up most of the pipeline, the limb
// multipliers with their adder trees and the sum registers the rest.
// Reset clears the matrix entries to zero, drops every request in flight and
// empties the response buffer.
// Results leave through a two-entry buffer. While the receiver stalls, new
// requests are still accepted until both entries hold results; then req
// ready falls and the whole pipeline holds its contents, losing nothing.
module sampson_epipolar_error_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   spe_csr_if.sink     csr_chan,
   spe_req_if.sink     req_chan,
   spe_rsp_if.source   rsp_chan
);
   import spe_pkg::*;

   // Coordinates carry FRAC fraction bits.
   localparam int FRAC = COORD_WIDTH - INT_BITS;
   // Width of a line or column term: two products plus a shifted entry.
   localparam int PA = COEF_WIDTH + COORD_WIDTH;
   localparam int LW = PA + 1;
   localparam int PX = COORD_WIDTH + LW;
   localparam int PS = 2 * LW;
   localparam int NW = PX + 1;
   localparam int DW = 2 * LW + 1;
   localparam int PN = 2 * NW;
   localparam int NSQW = PN - 1;
   // The common power of two of numerator and denominator is dropped.
   localparam int NSH = (2 * FRAC < OUT_FRAC) ? OUT_FRAC - 2 * FRAC : 0;
   localparam int DSH = (2 * FRAC > OUT_FRAC) ? 2 * FRAC - OUT_FRAC : 0;
   localparam int NUMW = NSQW + NSH;
   localparam int DENW = DW + DSH;
   localparam int MULS_A = 10;
   localparam int LAT_A = mul_latency(PA);
   localparam int LAT_B = (mul_latency(PX) > mul_latency(PS)) ?
                          mul_latency(PX) : mul_latency(PS);
   localparam int LAT_C = mul_latency(PN);
   localparam int TOTAL = LAT_A + 1 + LAT_B + 1 + LAT_C + QUOT_BITS;

   typedef struct packed {
      logic [OUT_BITS-1:0] error_value;
      status_type          status;
   } result_type;

   // ------------------------------------------------------------------
   // Matrix entries, row-major m00 .. m22.
   // ------------------------------------------------------------------
   logic signed [COEF_WIDTH-1:0] coef_ff [NUM_COEFS];
   logic [COEF_WIDTH-1:0]        csr_lo;
   logic [COEF_WIDTH-1:0]        csr_hi;
   logic                         csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write = csr_chan.valid && csr_chan.ready;
   assign csr_lo = csr_chan.data[COEF_WIDTH-1:0];
   assign csr_hi = csr_chan.data[CSR_HALF +: COEF_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_chan.index)
            CSR_COEF_PAIR_0: begin
               coef_ff[0] <= csr_lo;
               coef_ff[1] <= csr_hi;
            end
            CSR_COEF_PAIR_1: begin
               coef_ff[2] <= csr_lo;
               coef_ff[3] <= csr_hi;
            end
            CSR_COEF_PAIR_2: begin
               coef_ff[4] <= csr_lo;
               coef_ff[5] <= csr_hi;
            end
            CSR_COEF_PAIR_3: begin
               coef_ff[6] <= csr_lo;
               coef_ff[7] <= csr_hi;
            end
            CSR_COEF_LAST: begin
               coef_ff[8] <= csr_lo;
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control. All stages advance together while the response
   // buffer has a free entry; the valid bits shift with the data.
   // ------------------------------------------------------------------
   logic             en;
   logic             accept;
   logic [TOTAL-1:0] valid_ff;
   logic             head_v_ff;
   logic             skid_v_ff;

   assign en = !skid_v_ff;
   assign req_chan.ready = en;
   assign accept = req_chan.valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[TOTAL-2:0], accept};
      end
   end

   // ------------------------------------------------------------------
   // Stage group A: entry times coordinate products.
   // ------------------------------------------------------------------
   logic signed [COEF_WIDTH-1:0]  a_coef  [MULS_A];
   logic signed [COORD_WIDTH-1:0] a_coord [MULS_A];
   logic signed [PA-1:0]          a_prod  [MULS_A];

   // Lines: m00*x1, m01*y1, m10*x1, m11*y1, m20*x1, m21*y1.
   // Columns: m00*x2, m10*y2, m01*x2, m11*y2.
   assign a_coef[0] = coef_ff[0];
   assign a_coef[1] = coef_ff[1];
   assign a_coef[2] = coef_ff[3];
   assign a_coef[3] = coef_ff[4];
   assign a_coef[4] = coef_ff[6];
   assign a_coef[5] = coef_ff[7];
   assign a_coef[6] = coef_ff[0];
   assign a_coef[7] = coef_ff[3];
   assign a_coef[8] = coef_ff[1];
   assign a_coef[9] = coef_ff[4];

   assign a_coord[0] = req_chan.first_x;
   assign a_coord[1] = req_chan.first_y;
   assign a_coord[2] = req_chan.first_x;
   assign a_coord[3] = req_chan.first_y;
   assign a_coord[4] = req_chan.first_x;
   assign a_coord[5] = req_chan.first_y;
   assign a_coord[6] = req_chan.second_x;
   assign a_coord[7] = req_chan.second_y;
   assign a_coord[8] = req_chan.second_x;
   assign a_coord[9] = req_chan.second_y;

   for (genvar g = 0; g < MULS_A; g++) begin : g_mul_a
      spe_wmul #(
         .A_WIDTH (COEF_WIDTH),
         .B_WIDTH (COORD_WIDTH),
         .LATENCY (LAT_A)
      ) u_mul (
         .clock (clock),
         .en    (en),
         .a     (a_coef[g]),
         .b     (a_coord[g]),
         .p     (a_prod[g])
      );
   end

   // The second point waits for the line terms.
   logic [2*COORD_WIDTH-1:0]      second_d;
   logic signed [COORD_WIDTH-1:0] x2_d;
   logic signed [COORD_WIDTH-1:0] y2_d;

   spe_delay #(
      .WIDTH (2 * COORD_WIDTH),
      .DEPTH (LAT_A + 1)
   ) u_second_delay (
      .clock (clock),
      .en    (en),
      .din   ({req_chan.second_y, req_chan.second_x}),
      .dout  (second_d)
   );

   assign x2_d = second_d[COORD_WIDTH-1:0];
   assign y2_d = second_d[2*COORD_WIDTH-1:COORD_WIDTH];

   // Line l = M*[p1;1] and the first two column terms of [p2;1]^T*M.
   logic signed [LW-1:0] l0_ff;
   logic signed [LW-1:0] l1_ff;
   logic signed [LW-1:0] l2_ff;
   logic signed [LW-1:0] a0_ff;
   logic signed [LW-1:0] a1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         l0_ff <= LW'(a_prod[0]) + LW'(a_prod[1]) + (LW'(coef_ff[2]) <<< FRAC);
         l1_ff <= LW'(a_prod[2]) + LW'(a_prod[3]) + (LW'(coef_ff[5]) <<< FRAC);
         l2_ff <= LW'(a_prod[4]) + LW'(a_prod[5]) + (LW'(coef_ff[8]) <<< FRAC);
         a0_ff <= LW'(a_prod[6]) + LW'(a_prod[7]) + (LW'(coef_ff[6]) <<< FRAC);
         a1_ff <= LW'(a_prod[8]) + LW'(a_prod[9]) + (LW'(coef_ff[7]) <<< FRAC);
      end
   end

   // ------------------------------------------------------------------
   // Stage group B: numerator products and the four squares.
   // ------------------------------------------------------------------
   logic signed [PX-1:0] nx_prod;
   logic signed [PX-1:0] ny_prod;
   logic signed [LW-1:0] sq_in   [4];
   logic signed [PS-1:0] sq_prod [4];
   logic [LW-1:0]        l2_d;

   spe_wmul #(
      .A_WIDTH (COORD_WIDTH),
      .B_WIDTH (LW),
      .LATENCY (LAT_B)
   ) u_mul_nx (
      .clock (clock),
      .en    (en),
      .a     (x2_d),
      .b     (l0_ff),
      .p     (nx_prod)
   );

   spe_wmul #(
      .A_WIDTH (COORD_WIDTH),
      .B_WIDTH (LW),
      .LATENCY (LAT_B)
   ) u_mul_ny (
      .clock (clock),
      .en    (en),
      .a     (y2_d),
      .b     (l1_ff),
      .p     (ny_prod)
   );

   assign sq_in[0] = a0_ff;
   assign sq_in[1] = a1_ff;
   assign sq_in[2] = l0_ff;
   assign sq_in[3] = l1_ff;

   for (genvar g = 0; g < 4; g++) begin : g_square
      spe_wmul #(
         .A_WIDTH (LW),
         .B_WIDTH (LW),
         .LATENCY (LAT_B)
      ) u_mul (
         .clock (clock),
         .en    (en),
         .a     (sq_in[g]),
         .b     (sq_in[g]),
         .p     (sq_prod[g])
      );
   end

   spe_delay #(
      .WIDTH (LW),
      .DEPTH (LAT_B)
   ) u_l2_delay (
      .clock (clock),
      .en    (en),
      .din   (l2_ff),
      .dout  (l2_d)
   );

   // Numerator n = [p2;1].l and denominator d. Each square is nonnegative
   // and fits one bit below its product width.
   logic signed [NW-1:0] n_ff;
   logic [DW-1:0]        d_ff;
   logic signed [LW-1:0] l2_s;

   assign l2_s = l2_d;

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= NW'(nx_prod) + NW'(ny_prod) + (NW'(l2_s) <<< FRAC);
         d_ff <= DW'(sq_prod[0][PS-2:0]) + DW'(sq_prod[1][PS-2:0])
               + DW'(sq_prod[2][PS-2:0]) + DW'(sq_prod[3][PS-2:0]);
      end
   end

   // ------------------------------------------------------------------
   // Stage group C: n squared; d waits alongside.
   // ------------------------------------------------------------------
   logic signed [PN-1:0] nsq_prod;
   logic [DW-1:0]        d_d;

   spe_wmul #(
      .A_WIDTH (NW),
      .B_WIDTH (NW),
      .LATENCY (LAT_C)
   ) u_mul_nsq (
      .clock (clock),
      .en    (en),
      .a     (n_ff),
      .b     (n_ff),
      .p     (nsq_prod)
   );

   spe_delay #(
      .WIDTH (DW),
      .DEPTH (LAT_C)
   ) u_d_delay (
      .clock (clock),
      .en    (en),
      .din   (d_ff),
      .dout  (d_d)
   );

   // ------------------------------------------------------------------
   // Stage group D: quotient of n*n*2^24 by d*2^(2*FRAC).
   // ------------------------------------------------------------------
   logic [NUMW-1:0]      div_num;
   logic [DENW-1:0]      div_den;
   logic [QUOT_BITS-1:0] quot;
   logic                 den_zero;

   assign div_num = NUMW'(nsq_prod[NSQW-1:0]) << NSH;
   assign div_den = DENW'(d_d) << DSH;

   spe_divider #(
      .NUM_WIDTH (NUMW),
      .DEN_WIDTH (DENW)
   ) u_divider (
      .clock    (clock),
      .en       (en),
      .num      (div_num),
      .den      (div_den),
      .quot     (quot),
      .den_zero (den_zero)
   );

   // A zero denominator takes precedence over saturation.
   result_type result;

   always_comb begin
      result.error_value = quot[OUT_BITS-1:0];
      result.status = STATUS_OK;
      if (den_zero) begin
         result.error_value = '1;
         result.status = STATUS_ZERO_DEN;
      end else if (quot[OUT_BITS]) begin
         result.error_value = '1;
         result.status = STATUS_SAT;
      end
   end

   // ------------------------------------------------------------------
   // Two-entry response buffer: head drives the rsp channel, the skid entry
   // catches the result that arrives while the head waits.
   // ------------------------------------------------------------------
   logic       push;
   logic       pop;
   logic       head_v_in;
   logic       skid_v_in;
   result_type head_ff;
   result_type skid_ff;
   result_type head_in;
   result_type skid_in;

   assign push = en && valid_ff[TOTAL-1];
   assign pop = head_v_ff && rsp_chan.ready;

   always_comb begin
      head_v_in = head_v_ff;
      skid_v_in = skid_v_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      if (pop) begin
         head_v_in = skid_v_ff;
         head_in = skid_ff;
         skid_v_in = 1'b0;
      end
      if (push) begin
         if (head_v_in) begin
            skid_v_in = 1'b1;
            skid_in = result;
         end else begin
            head_v_in = 1'b1;
            head_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid = head_v_ff;
   assign rsp_chan.error_value = head_ff.error_value;
   assign rsp_chan.status = head_ff.status;

`ifndef NO_ASSERTIONS
   // An accepted request enters the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff[0])
      else $error("accepted request did not enter the pipeline");

   // The skid entry is filled only behind a waiting head.
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> head_v_ff)
      else $error("response buffer holds a result out of order");

   // A frozen pipeline keeps every item in flight.
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the squared Sampson error engine.
// A clocked driver feeds point correspondences from a queue of pending
// requests, a clocked monitor predicts each result at the moment its request
// is accepted, and it checks the responses in order against those predictions.
module tb;
   import spe_pkg::*;

   localparam int COORD_WIDTH = 32;
   localparam int COEF_WIDTH = 32;
   localparam int COORD_FRAC = COORD_WIDTH - INT_BITS;
   localparam int WIDE = 256;
   localparam int IDLE_PCT = 38;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_PAIRS = 165;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT = 200000;

   localparam logic [OUT_BITS-1:0] ERROR_MAX = '1;
   localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] WORD_MIN = 32'h8000_0000;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = CSR_COEF_LAST + 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = '1;

   typedef logic signed [WIDE-1:0] wide_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] first_x;
      logic [COORD_WIDTH-1:0] first_y;
      logic [COORD_WIDTH-1:0] second_x;
      logic [COORD_WIDTH-1:0] second_y;
   } point_pair_type;

   typedef struct {
      logic [OUT_BITS-1:0] error_value;
      status_type          status;
   } sampson_result_type;

   // Matrix shapes the bench loads between phases.
   typedef enum {
      MAT_ZERO,
      MAT_LAST_ONLY,
      MAT_ALL_MAX,
      MAT_ALL_MIN,
      MAT_SKEW,
      MAT_RANDOM,
      MAT_SMALL
   } matrix_kind_type;

   // How a correspondence is drawn. Points on the epipolar line of a skew
   // matrix give an exact zero numerator, so nearby points give small errors.
   typedef enum {
      PAIR_WILD,
      PAIR_SMALL,
      PAIR_ON_LINE
   } pair_style_type;

   logic clock;
   logic reset;

   spe_csr_if                              csr_chan ();
   spe_req_if #(.COORD_WIDTH(COORD_WIDTH)) req_chan ();
   spe_rsp_if                              rsp_chan ();

   sampson_epipolar_error_unit #(
      .COORD_WIDTH(COORD_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .csr_chan(csr_chan),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Matrix entries as the block should hold them, row-major.
   logic [COEF_WIDTH-1:0] coef_model [NUM_COEFS];

   point_pair_type     pending_pairs [$];
   sampson_result_type expected_errors [$];

   int unsigned mismatch_count = 0;
   int unsigned queued_total = 0;
   int unsigned rsp_count = 0;
   logic        req_accepted;
   logic        steady_flow;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Exact fixed-point evaluation of the squared Sampson error. Every sum and
   // product is carried at full precision in a 256-bit signed word; only the
   // final quotient is truncated.
   function automatic void predict_sampson(input point_pair_type p,
                                           output sampson_result_type r);
      wide_type    m [NUM_COEFS];
      wide_type    x1, y1, x2, y2;
      wide_type    l0, l1, l2, n, a0, a1, den_sum;
      logic [WIDE-1:0] num, den, quo;
      int          i;
      for (i = 0; i < NUM_COEFS; i++) begin
         m[i] = $signed(coef_model[i]);
      end
      x1 = $signed(p.first_x);
      y1 = $signed(p.first_y);
      x2 = $signed(p.second_x);
      y2 = $signed(p.second_y);

      // Epipolar line of the first point; the homogeneous one is 2^COORD_FRAC.
      l0 = m[0] * x1 + m[1] * y1 + (m[2] <<< COORD_FRAC);
      l1 = m[3] * x1 + m[4] * y1 + (m[5] <<< COORD_FRAC);
      l2 = m[6] * x1 + m[7] * y1 + (m[8] <<< COORD_FRAC);
      n  = x2 * l0 + y2 * l1 + (l2 <<< COORD_FRAC);

      // Second point against the first two columns of the matrix.
      a0 = x2 * m[0] + y2 * m[3] + (m[6] <<< COORD_FRAC);
      a1 = x2 * m[1] + y2 * m[4] + (m[7] <<< COORD_FRAC);
      den_sum = a0 * a0 + a1 * a1 + l0 * l0 + l1 * l1;

      if (den_sum == 0) begin
         r.error_value = ERROR_MAX;
         r.status = STATUS_ZERO_DEN;
      end else begin
         // Numerator and denominator scales differ by 2*COORD_FRAC, and the
         // result carries OUT_FRAC fraction bits.
         num = n * n;
         num = num << OUT_FRAC;
         den = den_sum;
         den = den << (2 * COORD_FRAC);
         quo = num / den;
         if (quo > ERROR_MAX) begin
            r.error_value = ERROR_MAX;
            r.status = STATUS_SAT;
         end else begin
            r.error_value = quo[OUT_BITS-1:0];
            r.status = STATUS_OK;
         end
      end
   endfunction

   function automatic logic [31:0] rand_signed(input int bits);
      return 32'($urandom_range((2 << bits) - 1)) - 32'(1 << bits);
   endfunction

   function automatic point_pair_type make_pair(input pair_style_type style);
      point_pair_type p;
      int             noise_bits;
      case (style)
         PAIR_SMALL: begin
            p.first_x = rand_signed($urandom_range(29, 4));
            p.first_y = rand_signed($urandom_range(29, 4));
            p.second_x = rand_signed($urandom_range(29, 4));
            p.second_y = rand_signed($urandom_range(29, 4));
         end
         PAIR_ON_LINE: begin
            p.first_x = rand_signed(28);
            p.first_y = rand_signed(28);
            noise_bits = $urandom_range(16);
            if ($urandom_range(3) == 0) begin
               p.second_x = p.first_x;
               p.second_y = p.first_y;
            end else begin
               p.second_x = p.first_x + rand_signed(noise_bits);
               p.second_y = p.first_y + rand_signed(noise_bits);
            end
         end
         default: begin
            p.first_x = $urandom();
            p.first_y = $urandom();
            p.second_x = $urandom();
            p.second_y = $urandom();
         end
      endcase
      return p;
   endfunction

   // Pairs are only queued in a rising-edge time step, so the driver, which
   // pops at the falling edge, never races with the producer.
   function automatic void queue_pair(input point_pair_type p);
      pending_pairs.insert(pending_pairs.size(), p);
      queued_total++;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data <= data;
      do @(posedge clock);
      while (csr_chan.ready !== 1'b1);
   endtask

   // Builds a matrix of the given shape and writes all five registers. Now and
   // then a write to an unused index is added; the block must ignore it.
   task automatic load_matrix(input matrix_kind_type kind);
      logic [COEF_WIDTH-1:0] m [NUM_COEFS];
      logic [COEF_WIDTH-1:0] tx, ty, tz;
      int                    i;
      for (i = 0; i < NUM_COEFS; i++) begin
         m[i] = '0;
      end
      case (kind)
         MAT_LAST_ONLY: begin
            case ($urandom_range(2))
               0: m[8] = WORD_MAX;
               1: m[8] = WORD_MIN;
               default: m[8] = $urandom();
            endcase
         end
         MAT_ALL_MAX: begin
            for (i = 0; i < NUM_COEFS; i++) m[i] = WORD_MAX;
         end
         MAT_ALL_MIN: begin
            for (i = 0; i < NUM_COEFS; i++) m[i] = WORD_MIN;
         end
         MAT_SKEW: begin
            // Cross-product matrix of a translation: p^T M p is zero for all p.
            tx = rand_signed(29);
            ty = rand_signed(29);
            tz = rand_signed(29);
            m[1] = -tz;
            m[2] = ty;
            m[3] = tz;
            m[5] = -tx;
            m[6] = -ty;
            m[7] = tx;
         end
         MAT_RANDOM: begin
            for (i = 0; i < NUM_COEFS; i++) m[i] = $urandom();
         end
         MAT_SMALL: begin
            for (i = 0; i < NUM_COEFS; i++) m[i] = rand_signed($urandom_range(29, 6));
         end
         default: ;
      endcase
      write_reg(CSR_COEF_PAIR_0, {m[1], m[0]});
      write_reg(CSR_COEF_PAIR_1, {m[3], m[2]});
      write_reg(CSR_COEF_PAIR_2, {m[5], m[4]});
      write_reg(CSR_COEF_PAIR_3, {m[7], m[6]});
      // The upper half of the last register carries junk that must not matter.
      write_reg(CSR_COEF_LAST, {32'($urandom()), m[8]});
      if ($urandom_range(3) == 0) begin
         write_reg(CSR_INDEX_WIDTH'($urandom_range(CSR_SPARE_HI, CSR_SPARE_LO)),
                   {32'($urandom()), 32'($urandom())});
      end
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every queued request has produced its response. The count
   // is read at the falling edge, away from the edge where it changes, and
   // the task returns in a rising-edge time step.
   task automatic wait_drained();
      do @(negedge clock);
      while (rsp_count < queued_total);
      repeat (4) @(negedge clock);
      @(posedge clock);
   endtask

   // Request driver. A held request stays on the bus until it is taken; the
   // next one may follow in the very next cycle or after a random gap.
   always @(negedge clock) begin : drive_pairs
      point_pair_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.first_x <= '0;
         req_chan.first_y <= '0;
         req_chan.second_x <= '0;
         req_chan.second_y <= '0;
      end else if (!req_chan.valid || req_accepted) begin
         if (pending_pairs.size() != 0 &&
             (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = pending_pairs.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.first_x <= nxt.first_x;
            req_chan.first_y <= nxt.first_y;
            req_chan.second_x <= nxt.second_x;
            req_chan.second_y <= nxt.second_y;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // The response side stalls at random, except during the steady stretch.
   always @(negedge clock) begin
      rsp_chan.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   // Monitor: tracks register writes, predicts each accepted request and
   // compares every response with the oldest prediction still waiting.
   always @(posedge clock) begin : watch_channels
      sampson_result_type want;
      int                 i;
      if (reset) begin
         for (i = 0; i < NUM_COEFS; i++) coef_model[i] = '0;
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_chan.valid && req_chan.ready;

         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_COEF_PAIR_0: begin
                  coef_model[0] = csr_chan.data[CSR_HALF-1:0];
                  coef_model[1] = csr_chan.data[CSR_DATA_WIDTH-1:CSR_HALF];
               end
               CSR_COEF_PAIR_1: begin
                  coef_model[2] = csr_chan.data[CSR_HALF-1:0];
                  coef_model[3] = csr_chan.data[CSR_DATA_WIDTH-1:CSR_HALF];
               end
               CSR_COEF_PAIR_2: begin
                  coef_model[4] = csr_chan.data[CSR_HALF-1:0];
                  coef_model[5] = csr_chan.data[CSR_DATA_WIDTH-1:CSR_HALF];
               end
               CSR_COEF_PAIR_3: begin
                  coef_model[6] = csr_chan.data[CSR_HALF-1:0];
                  coef_model[7] = csr_chan.data[CSR_DATA_WIDTH-1:CSR_HALF];
               end
               CSR_COEF_LAST: begin
                  coef_model[8] = csr_chan.data[CSR_HALF-1:0];
               end
               default: ;
            endcase
         end

         if (req_chan.valid && req_chan.ready) begin
            predict_sampson({req_chan.first_x, req_chan.first_y,
                             req_chan.second_x, req_chan.second_y}, want);
            expected_errors.insert(expected_errors.size(), want);
         end

         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_count++;
            if (expected_errors.size() == 0) begin
               $display("%0t: response with no request outstanding, got value %h status %0d",
                        $time, rsp_chan.error_value, rsp_chan.status);
               mismatch_count++;
            end else begin
               want = expected_errors.pop_front();
               if (rsp_chan.error_value !== want.error_value ||
                   rsp_chan.status !== want.status) begin
                  $display("%0t: mismatch, expected value %h status %0d, got value %h status %0d",
                           $time, want.error_value, want.status,
                           rsp_chan.error_value, rsp_chan.status);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      matrix_kind_type kind;
      pair_style_type  style;
      point_pair_type  p;
      int              ph;
      int              idx;
      int              pick;

      reset = 1'b1;
      steady_flow = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The matrix is all zero out of reset, so every denominator is zero.
      queue_pair('{'0, '0, '0, '0});
      queue_pair('{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX});
      queue_pair('{WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX});
      wait_drained();

      // Only the last entry set: the numerator is nonzero yet the denominator
      // still vanishes, which must be flagged as a zero denominator.
      load_matrix(MAT_LAST_ONLY);
      queue_pair('{'0, '0, '0, '0});
      queue_pair(make_pair(PAIR_WILD));
      wait_drained();

      // Extreme matrices against extreme points; these mostly saturate.
      load_matrix(MAT_ALL_MAX);
      queue_pair('{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX});
      queue_pair('{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN});
      queue_pair('{'0, '0, '0, '0});
      queue_pair('{WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN});
      wait_drained();

      load_matrix(MAT_ALL_MIN);
      queue_pair('{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX});
      queue_pair('{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN});
      queue_pair('{'0, '0, '0, '0});
      queue_pair('{WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN});
      wait_drained();

      // Matched points under a cross-product matrix give an error of zero.
      load_matrix(MAT_SKEW);
      p = make_pair(PAIR_SMALL);
      queue_pair('{p.first_x, p.first_y, p.first_x, p.first_y});
      queue_pair('{WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN});
      queue_pair(make_pair(PAIR_ON_LINE));
      queue_pair(make_pair(PAIR_ON_LINE));
      wait_drained();

      load_matrix(MAT_RANDOM);
      queue_pair(make_pair(PAIR_WILD));
      queue_pair(make_pair(PAIR_WILD));
      wait_drained();

      // Random phases, each under a fresh matrix. Most phases use matrices
      // with a meaningful error range; the extremes come up now and then.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         pick = $urandom_range(99);
         if (pick < 40) kind = MAT_SKEW;
         else if (pick < 60) kind = MAT_RANDOM;
         else if (pick < 90) kind = MAT_SMALL;
         else if (pick < 94) kind = MAT_ALL_MAX;
         else if (pick < 97) kind = MAT_ALL_MIN;
         else if (pick < 99) kind = MAT_LAST_ONLY;
         else kind = MAT_ZERO;
         load_matrix(kind);

         // One phase runs with no idling on either side.
         steady_flow = (ph == 2);

         for (idx = 0; idx < PHASE_PAIRS; idx++) begin
            // Halfway through one phase the sender holds back until every
            // response so far has come home.
            if (ph == 5 && idx == PHASE_PAIRS / 2) wait_drained();
            pick = $urandom_range(99);
            if (kind == MAT_SKEW) begin
               if (pick < 60) style = PAIR_ON_LINE;
               else if (pick < 85) style = PAIR_SMALL;
               else style = PAIR_WILD;
            end else begin
               style = (pick < 55) ? PAIR_SMALL : PAIR_WILD;
            end
            queue_pair(make_pair(style));
         end
         wait_drained();
         steady_flow = 1'b0;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_errors.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
